// ===== src/zero_padded_2d_window_convolution_core_macros.svh =====
// Assertion helpers shared by the RTL. They expect clk and arst_n in scope.
`ifndef ZERO_PADDED_2D_WINDOW_CONVOLUTION_CORE_MACROS_SVH
`define ZERO_PADDED_2D_WINDOW_CONVOLUTION_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ZPC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ZPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/zpc_pkg.sv =====
`timescale 1ns / 1ps
package zpc_pkg;
	localparam int KERNEL_SIZE = 3;
	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 4096;
	localparam int KMID        = KERNEL_SIZE / 2;
	localparam int KTAPS       = KERNEL_SIZE * KERNEL_SIZE;
	localparam int LINE_COLS   = MAX_WIDTH + KERNEL_SIZE;

	localparam int MODE_W  = 2;
	localparam int IDX_W   = 8;
	localparam int PIX_W   = 16;
	localparam int COEF_W  = 16;
	localparam int PROD_W  = 32;
	localparam int OUT_W   = 40;
	localparam int WCFG_W  = 11;
	localparam int HCFG_W  = 13;
	localparam int CFG_DW  = 13;
	localparam int CFG_IW  = 1;
	localparam int COL_W   = $clog2(MAX_WIDTH + KMID + 1);
	localparam int ROW_W   = $clog2(MAX_HEIGHT + KMID + 1);
	localparam int ADDR_W  = $clog2(LINE_COLS);
	localparam int SLOT_W  = (KERNEL_SIZE > 1) ? $clog2(KERNEL_SIZE) : 1;

	localparam logic [MODE_W-1:0] MODE_COEF  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PIXEL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PAD   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

	localparam logic [CFG_IW-1:0] REG_WIDTH  = 1'b0;
	localparam logic [CFG_IW-1:0] REG_HEIGHT = 1'b1;

	typedef logic signed [PIX_W-1:0]  pix_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [OUT_W-1:0]  sum_t;

	typedef struct packed {
		logic              shift;
		logic              adv;
		logic              coef_we;
		logic [IDX_W-1:0]  coef_idx;
		coef_t             coef_val;
	} cell_ctl_t;

	function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] s,
			input logic [SLOT_W:0] n);
		logic [SLOT_W:0] t;
		t = {1'b0, s} + n;
		if (t >= (SLOT_W+1)'(KERNEL_SIZE))
			t = t - (SLOT_W+1)'(KERNEL_SIZE);
		return t[SLOT_W-1:0];
	endfunction
endpackage

// ===== src/zpc_intf.sv =====
`timescale 1ns / 1ps
interface zpc_in_if;
	import zpc_pkg::*;
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [IDX_W-1:0]  coeff_index;
	coef_t             coeff_value;
	pix_t              pixel_value;
	modport source (output valid, mode, coeff_index, coeff_value, pixel_value, input ready);
	modport sink (input valid, mode, coeff_index, coeff_value, pixel_value, output ready);
endinterface

interface zpc_out_if;
	import zpc_pkg::*;
	logic valid;
	logic ready;
	sum_t filtered_value;
	logic last_of_frame;
	modport source (output valid, filtered_value, last_of_frame, input ready);
	modport sink (input valid, filtered_value, last_of_frame, output ready);
endinterface

// ===== src/zpc_ram.sv =====
`timescale 1ns / 1ps
module zpc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end
endmodule

// ===== src/zpc_cell.sv =====
`timescale 1ns / 1ps
module zpc_cell (
	input  logic                    clk,
	input  zpc_pkg::cell_ctl_t      ctl,
	input  logic [zpc_pkg::IDX_W-1:0] tap,
	input  zpc_pkg::pix_t           val_in,
	output zpc_pkg::pix_t           val_out,
	output zpc_pkg::prod_t          prod
);
	import zpc_pkg::*;

	pix_t  win_q;
	coef_t coef_q;
	prod_t prod_q;

	always_ff @(posedge clk) begin
		if (ctl.shift)
			win_q <= val_in;
		if (ctl.coef_we && ctl.coef_idx == tap)
			coef_q <= ctl.coef_val;
		if (ctl.adv)
			prod_q <= prod_t'(win_q) * prod_t'(coef_q);
	end

	assign val_out = win_q;
	assign prod    = prod_q;
endmodule

// ===== src/zero_padded_2d_window_convolution_core.sv =====
`timescale 1ns / 1ps
// A pixel or pad beat ending a window passes stage 1, the cells, row sums, output reg.
// Throughput: one input beat per cycle; the whole pipeline halts while a result waits.
// Reset: the line store is cleared over its LINE_COLS (1027) addresses, during which
// no beat is accepted; configuration writes are taken throughout.
// Coefficients hold no value after reset until they are written.
module zero_padded_2d_window_convolution_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [zpc_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [zpc_pkg::CFG_DW-1:0]  cfg_data,
	zpc_in_if.sink                      din,
	zpc_out_if.source                   dout
);
	import zpc_pkg::*;
	`include "zero_padded_2d_window_convolution_core_macros.svh"

	logic [WCFG_W-1:0] width_q;
	logic [HCFG_W-1:0] height_q;
	logic [COL_W-1:0]  col_q, w_eff, ext_w, col_inc;
	logic [ROW_W-1:0]  row_q, h_eff, ext_h, row_inc;
	logic [SLOT_W-1:0] slot_q;
	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_addr_q;

	logic adv, acc, is_px, is_coef, col_wrap, produce, last;
	logic [KERNEL_SIZE-1:0] rowzero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WCFG_W'(640);
			height_q <= HCFG_W'(480);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[WCFG_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[HCFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0)
			w_eff = COL_W'(1);
		else if (COL_W'(width_q) > COL_W'(MAX_WIDTH))
			w_eff = COL_W'(MAX_WIDTH);
		else
			w_eff = COL_W'(width_q);
		if (height_q == '0)
			h_eff = ROW_W'(1);
		else if (ROW_W'(height_q) > ROW_W'(MAX_HEIGHT))
			h_eff = ROW_W'(MAX_HEIGHT);
		else
			h_eff = ROW_W'(height_q);
		ext_w = w_eff + COL_W'(KMID);
		ext_h = h_eff + ROW_W'(KMID);
	end

	logic out_valid_q;
	sum_t out_data_q;
	logic out_last_q;

	assign adv       = !out_valid_q || dout.ready;
	assign din.ready = adv && !clr_busy_q;
	assign acc       = din.valid && din.ready;
	assign is_px     = din.mode == MODE_PIXEL || din.mode == MODE_PAD;
	assign is_coef   = din.mode == MODE_COEF && din.coeff_index < IDX_W'(KTAPS);
	assign col_inc   = col_q + COL_W'(1);
	assign row_inc   = row_q + ROW_W'(1);
	assign col_wrap  = col_inc >= ext_w;
	assign produce   = row_q >= ROW_W'(KMID) && col_q >= COL_W'(KMID)
		&& row_q < ext_h && col_q < ext_w;
	assign last      = row_q == ext_h - ROW_W'(1) && col_q == ext_w - COL_W'(1);

	always_comb begin
		for (int a = 0; a < KERNEL_SIZE; a++)
			rowzero[a] = row_q < ROW_W'(KERNEL_SIZE - 1 - a);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (acc && is_px) begin
			if (col_wrap) begin
				col_q <= '0;
				if (row_inc >= ext_h) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= row_inc;
					slot_q <= slot_add(slot_q, (SLOT_W+1)'(1));
				end
			end else begin
				col_q <= col_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (clr_addr_q == ADDR_W'(LINE_COLS - 1))
				clr_busy_q <= 1'b0;
		end
	end

	pix_t              wr_pix;
	logic [ADDR_W-1:0] wr_addr;
	pix_t              rd_data [KERNEL_SIZE];

	assign wr_pix  = (clr_busy_q || din.mode != MODE_PIXEL) ? '0 : din.pixel_value;
	assign wr_addr = clr_busy_q ? clr_addr_q : ADDR_W'(col_q);

	for (genvar k = 0; k < KERNEL_SIZE; k++) begin : g_line
		logic ram_we;
		assign ram_we = clr_busy_q || (acc && is_px && slot_q == SLOT_W'(k));
		zpc_ram #(.WIDTH(PIX_W), .DEPTH(LINE_COLS)) u_ram (
			.clk   (clk),
			.we    (ram_we),
			.waddr (wr_addr),
			.wdata (wr_pix),
			.re    (acc && is_px),
			.raddr (ADDR_W'(col_q)),
			.rdata (rd_data[k])
		);
	end

	logic                   v_s1, coef_s1, prod_s1, last_s1, colstart_s1;
	logic [KERNEL_SIZE-1:0] rowzero_s1;
	logic [SLOT_W-1:0]      slot_s1;
	pix_t                   pix_s1;
	logic [IDX_W-1:0]       idx_s1;
	coef_t                  cval_s1;
	logic                   prod_s2, last_s2, prod_s3, last_s3, prod_s4, last_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			prod_s2     <= 1'b0;
			prod_s3     <= 1'b0;
			prod_s4     <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= acc && (is_px || is_coef);
			prod_s2     <= v_s1 && !coef_s1 && prod_s1;
			prod_s3     <= prod_s2;
			prod_s4     <= prod_s3;
			out_valid_q <= prod_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			coef_s1     <= !is_px;
			prod_s1     <= produce;
			last_s1     <= last;
			colstart_s1 <= col_q == '0;
			rowzero_s1  <= rowzero;
			slot_s1     <= slot_q;
			pix_s1      <= (din.mode == MODE_PIXEL) ? din.pixel_value : '0;
			idx_s1      <= din.coeff_index;
			cval_s1     <= din.coeff_value;
			last_s2     <= last_s1;
			last_s3     <= last_s2;
			last_s4     <= last_s3;
			out_last_q  <= last_s4;
		end
	end

	cell_ctl_t ctl;
	assign ctl.shift    = adv && v_s1 && !coef_s1;
	assign ctl.adv      = adv;
	assign ctl.coef_we  = adv && v_s1 && coef_s1;
	assign ctl.coef_idx = idx_s1;
	assign ctl.coef_val = cval_s1;

	pix_t  col_val [KERNEL_SIZE];
	pix_t  win     [KERNEL_SIZE][KERNEL_SIZE];
	prod_t prods   [KERNEL_SIZE][KERNEL_SIZE];
	sum_t  rsum_s4 [KERNEL_SIZE];

	for (genvar a = 0; a < KERNEL_SIZE; a++) begin : g_row
		if (a == KERNEL_SIZE - 1) begin : g_new
			assign col_val[a] = pix_s1;
		end else begin : g_old
			assign col_val[a] = rowzero_s1[a] ? '0
				: rd_data[slot_add(slot_s1, (SLOT_W+1)'(a + 1))];
		end
		for (genvar b = 0; b < KERNEL_SIZE; b++) begin : g_col
			pix_t vin;
			if (b == KERNEL_SIZE - 1) begin : g_head
				assign vin = col_val[a];
			end else begin : g_tail
				assign vin = colstart_s1 ? '0 : win[a][b+1];
			end
			zpc_cell u_cell (
				.clk     (clk),
				.ctl     (ctl),
				.tap     (IDX_W'(a * KERNEL_SIZE + b)),
				.val_in  (vin),
				.val_out (win[a][b]),
				.prod    (prods[a][b])
			);
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sum_t acc_sum;
				acc_sum = '0;
				for (int b = 0; b < KERNEL_SIZE; b++)
					acc_sum = acc_sum + sum_t'(prods[a][b]);
				rsum_s4[a] <= acc_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_t tot;
			tot = '0;
			for (int a = 0; a < KERNEL_SIZE; a++)
				tot = tot + rsum_s4[a];
			out_data_q <= tot;
		end
	end

	assign dout.valid          = out_valid_q;
	assign dout.filtered_value = out_data_q;
	assign dout.last_of_frame  = out_last_q;

	`ZPC_ASSERT_SAME(a_no_accept_in_clear, clr_busy_q, !din.ready, "Beat accepted during clearing pass")
	`ZPC_ASSERT_NEXT(a_col_wrap, acc && is_px && col_wrap, col_q == '0, "Column failed to wrap")
	`ZPC_ASSERT_NEXT(a_stall_holds_pos, out_valid_q && !dout.ready, $stable(col_q) && $stable(row_q), "Position moved while stalled")
endmodule
